### hw/rtl/symbolic_mode_parser_assert.svh
// ----------------------------------------------------------------------------
// symbolic_mode_parser_assert.svh
// Assertion macros for the symbolic mode parser. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SYMBOLIC_MODE_PARSER_ASSERT_SVH
`define SYMBOLIC_MODE_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on i_clk, off during reset.
`define SMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("symbolic_mode_parser: assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SMP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("symbolic_mode_parser: assertion failed");

`else

`define SMP_ASSERT_IMP(lbl, ante, cons)
`define SMP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Types, character codes, mode masks and the clause apply function shared by
// the symbolic mode parser and its result buffer.
// ----------------------------------------------------------------------------
package smp_pkg;

    // mode bit groups
    localparam logic [11:0] M_USER   = 12'o5700;
    localparam logic [11:0] M_GROUP  = 12'o2070;
    localparam logic [11:0] M_OTHER  = 12'o0007;
    localparam logic [11:0] M_ALL    = 12'o7777;
    localparam logic [11:0] M_READ   = 12'o0444;
    localparam logic [11:0] M_WRITE  = 12'o0222;
    localparam logic [11:0] M_EXEC   = 12'o0111;
    localparam logic [11:0] M_SETID  = 12'o6000;
    localparam logic [11:0] M_STICKY = 12'o1000;
    localparam int unsigned SETGID_BIT = 10;
    localparam logic [3:0]  TYPE_DIR = 4'o04;

    localparam logic [11:0] DEFAULT_MASK_RESET = 12'o0022;

    // configuration register indexes
    localparam logic CFG_START_MODE   = 1'b0;
    localparam logic CFG_DEFAULT_MASK = 1'b1;

    // ASCII codes
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D7    = 8'h37;

    typedef enum logic [2:0] {
        PH_CLASS = 3'b001,
        PH_PERM  = 3'b010,
        PH_COPY  = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_SET  = 2'd3
    } t_op;

    typedef struct packed {
        logic [15:0] mode;
        logic [8:0]  umask;
        logic        bad;
    } t_result;

    typedef struct packed {
        logic main_full;
        logic skid_full;
    } t_buf_status;

    typedef struct packed {
        logic [15:0] mode;
        logic        touched;
    } t_apply;

    function automatic t_op op_code(input logic [7:0] c);
        t_op op;
        priority if (c == CH_PLUS)  op = OP_ADD;
        else if (c == CH_MINUS)     op = OP_SUB;
        else if (c == CH_EQ)        op = OP_SET;
        else                        op = OP_NONE;
        return op;
    endfunction

    // apply one pending operation to the working mode
    function automatic t_apply apply_op(
        input logic [15:0] wm,
        input t_op         op,
        input logic [11:0] perm,
        input logic [11:0] cls,
        input logic [11:0] excl,
        input logic        touched
    );
        t_apply      res;
        logic [11:0] keep;
        keep        = perm & cls & ~excl;
        res.mode    = wm;
        res.touched = touched;
        unique case (op)
            OP_ADD: begin
                res.mode    = wm | {4'b0000, keep};
                res.touched = touched | perm[SETGID_BIT];
            end
            OP_SUB: begin
                res.mode    = wm & ~{4'b0000, keep};
                res.touched = touched | perm[SETGID_BIT];
            end
            OP_SET: begin
                res.mode = (wm & ~{4'b0000, cls}) | {4'b0000, keep};
            end
            OP_NONE: begin
                res.mode = wm;
            end
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/symbolic_mode_parser.sv
// ----------------------------------------------------------------------------
// symbolic_mode_parser
// A result is written into the result buffer on its last character
//   transfer; throughput is one character per cycle while the skid slot is
//   empty, set by the combinational parse step between the state registers.
// Reset (synchronous, active low): start_mode 0, default_mask 022, parser back
//   to the start of a string, result buffer empty.
// ----------------------------------------------------------------------------
`include "symbolic_mode_parser_assert.svh"

module symbolic_mode_parser import smp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // character channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_new_mode,
    output logic [8:0]  o_new_umask,
    output logic        o_bad_string
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_start_mode;
    logic [11:0] r_default_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mode   <= '0;
            r_default_mask <= DEFAULT_MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_MODE:   r_start_mode   <= i_cfg_data;
                CFG_DEFAULT_MASK: r_default_mask <= i_cfg_data[11:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_phase      r_phase,  n_phase;
    logic [11:0] r_class,  n_class;
    logic [11:0] r_excl,   n_excl;
    t_op         r_op,     n_op;
    logic [11:0] r_perm,   n_perm;
    logic        r_first,  n_first;
    logic        r_touched, n_touched;
    logic [15:0] r_wm,     n_wm;
    logic [15:0] r_octal,  n_octal;
    logic        r_all_octal, n_all_octal;
    logic        r_error,  n_error;

    logic        w_accept;
    logic        w_digit;
    logic        w_is_dir;
    logic        w_x_ok;
    logic        w_copy_ch;
    t_op         w_op;
    logic        w_sym;
    logic        w_handled;
    logic [2:0]  w_fill;
    t_apply      w_app;
    t_apply      w_fin;
    logic [15:0] w_nm;
    logic        w_touch_fin;
    logic        w_push;
    t_result     w_res;
    t_buf_status w_buf;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_digit   = (i_char_code >= CH_D0) && (i_char_code <= CH_D7);
    assign w_is_dir  = (r_start_mode[15:12] == TYPE_DIR);
    // X gives execute on a directory or on anything already executable
    assign w_x_ok    = w_is_dir || (|(r_start_mode[11:0] & M_EXEC));
    assign w_copy_ch = (i_char_code == CH_U) || (i_char_code == CH_G) ||
                       (i_char_code == CH_O);
    assign w_op      = op_code(i_char_code);

    // One character per transfer. The n_ values are built up in order:
    // octal run, switch to symbolic text, class letters, permission
    // letters, then a closing operator or comma. On the last character the
    // pending operation is folded in and the result is formed.
    always_comb begin
        n_phase     = r_phase;
        n_class     = r_class;
        n_excl      = r_excl;
        n_op        = r_op;
        n_perm      = r_perm;
        n_first     = r_first;
        n_touched   = r_touched;
        n_wm        = r_wm;
        n_octal     = r_octal;
        n_all_octal = r_all_octal;
        n_error     = r_error;
        w_sym       = 1'b0;
        w_handled   = 1'b0;
        w_fill      = '0;
        w_app       = '0;
        w_fin       = '0;
        w_nm        = '0;
        w_touch_fin = 1'b0;
        w_push      = 1'b0;
        w_res       = '0;

        if (w_accept && !r_error) begin
            w_sym = 1'b1;
            if (r_all_octal) begin
                if (w_digit) begin
                    // wraps at 16 bits
                    n_octal = {r_octal[12:0], 3'b000} | {13'd0, i_char_code[2:0]};
                    w_sym   = 1'b0;
                end else begin
                    // first symbolic character: take start_mode as it is now
                    n_all_octal = 1'b0;
                    n_wm        = r_start_mode;
                    n_phase     = PH_CLASS;
                    n_class     = '0;
                    n_excl      = '0;
                    n_op        = OP_NONE;
                    n_perm      = '0;
                    n_first     = 1'b1;
                end
            end

            if (w_sym) begin
                if (n_phase == PH_CLASS) begin
                    priority if (i_char_code == CH_U) begin
                        n_class = n_class | M_USER;
                    end else if (i_char_code == CH_G) begin
                        n_class = n_class | M_GROUP;
                    end else if (i_char_code == CH_O) begin
                        n_class = n_class | M_OTHER;
                    end else if (i_char_code == CH_A) begin
                        n_class = n_class | M_ALL;
                    end else if (w_op != OP_NONE) begin
                        // no class named: all bits but the default mask
                        if (n_class == '0) begin
                            n_class = M_ALL;
                            n_excl  = r_default_mask;
                        end else begin
                            n_excl = '0;
                        end
                        n_op    = w_op;
                        n_perm  = '0;
                        n_first = 1'b1;
                        n_phase = PH_PERM;
                    end else if (i_char_code == CH_COMMA) begin
                        n_class = '0;
                        n_excl  = '0;
                        n_op    = OP_NONE;
                        n_perm  = '0;
                        n_first = 1'b1;
                    end else begin
                        n_error = 1'b1;
                    end
                end else begin
                    if (n_phase == PH_PERM && n_first && w_copy_ch) begin
                        // copy rwx of one class into all three
                        priority if (i_char_code == CH_U) w_fill = n_wm[8:6];
                        else if (i_char_code == CH_G)     w_fill = n_wm[5:3];
                        else                              w_fill = n_wm[2:0];
                        n_perm    = {3'b000, w_fill, w_fill, w_fill};
                        n_phase   = PH_COPY;
                        w_handled = 1'b1;
                    end else if (n_phase == PH_PERM) begin
                        w_handled = 1'b1;
                        priority if (i_char_code == CH_R) begin
                            n_perm = n_perm | M_READ;
                        end else if (i_char_code == CH_W) begin
                            n_perm = n_perm | M_WRITE;
                        end else if (i_char_code == CH_X) begin
                            n_perm = n_perm | M_EXEC;
                        end else if (i_char_code == CH_XU) begin
                            if (w_x_ok) n_perm = n_perm | M_EXEC;
                        end else if (i_char_code == CH_S) begin
                            n_perm = n_perm | M_SETID;
                        end else if (i_char_code == CH_T) begin
                            n_perm = n_perm | M_STICKY;
                        end else if (i_char_code == CH_L) begin
                            // locking letter: accepted, no effect
                        end else begin
                            w_handled = 1'b0;
                        end
                        if (w_handled) n_first = 1'b0;
                    end

                    if (!w_handled) begin
                        w_app = apply_op(n_wm, n_op, n_perm, n_class, n_excl, n_touched);
                        if (w_op != OP_NONE) begin
                            n_wm      = w_app.mode;
                            n_touched = w_app.touched;
                            n_op      = w_op;
                            n_perm    = '0;
                            n_first   = 1'b1;
                            n_phase   = PH_PERM;
                        end else if (i_char_code == CH_COMMA) begin
                            n_wm      = w_app.mode;
                            n_touched = w_app.touched;
                            n_phase   = PH_CLASS;
                            n_class   = '0;
                            n_excl    = '0;
                            n_op      = OP_NONE;
                            n_perm    = '0;
                            n_first   = 1'b1;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                end
            end
        end

        if (w_accept && i_last_char) begin
            w_push = 1'b1;
            if (n_error) begin
                w_nm = r_start_mode;
            end else begin
                if (n_all_octal) begin
                    w_nm        = n_octal;
                    w_touch_fin = n_touched;
                end else if (n_phase != PH_CLASS) begin
                    // close the list still open at end of string
                    w_fin       = apply_op(n_wm, n_op, n_perm, n_class, n_excl, n_touched);
                    w_nm        = w_fin.mode;
                    w_touch_fin = w_fin.touched;
                end else begin
                    w_nm        = n_wm;
                    w_touch_fin = n_touched;
                end
                // directories keep setgid unless a clause changed it
                if (w_is_dir && !w_touch_fin) w_nm[SETGID_BIT] = r_start_mode[SETGID_BIT];
            end
            w_res.mode  = w_nm;
            w_res.umask = ~w_nm[8:0];
            w_res.bad   = n_error;

            // back to the start of a string
            n_phase     = PH_CLASS;
            n_class     = '0;
            n_excl      = '0;
            n_op        = OP_NONE;
            n_perm      = '0;
            n_first     = 1'b1;
            n_touched   = 1'b0;
            n_octal     = '0;
            n_all_octal = 1'b1;
            n_error     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CLASS;
            r_class     <= '0;
            r_excl      <= '0;
            r_op        <= OP_NONE;
            r_perm      <= '0;
            r_first     <= 1'b1;
            r_touched   <= 1'b0;
            r_octal     <= '0;
            r_all_octal <= 1'b1;
            r_error     <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_class     <= n_class;
            r_excl      <= n_excl;
            r_op        <= n_op;
            r_perm      <= n_perm;
            r_first     <= n_first;
            r_touched   <= n_touched;
            r_octal     <= n_octal;
            r_all_octal <= n_all_octal;
            r_error     <= n_error;
        end
    end

    // working mode is reloaded before any use, so it needs no reset
    always_ff @(posedge i_clk) begin
        r_wm <= n_wm;
    end

    // ------------------------------------------------------------------
    // Result buffer: characters keep flowing until both slots are full
    // ------------------------------------------------------------------
    t_result w_out;

    smp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_res),
        .o_status (w_buf),
        .o_valid  (o_out_valid),
        .o_data   (w_out),
        .i_ready  (i_out_ready)
    );

    assign o_in_ready   = !w_buf.skid_full;
    assign o_new_mode   = w_out.mode;
    assign o_new_umask  = w_out.umask;
    assign o_bad_string = w_out.bad;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SMP_ASSERT_NXT(a_last_gives_result, w_accept && i_last_char, o_out_valid)
    `SMP_ASSERT_IMP(a_skid_needs_main, w_buf.skid_full, w_buf.main_full)
    `SMP_ASSERT_IMP(a_error_only_symbolic, r_error, !r_all_octal)
    `SMP_ASSERT_IMP(a_umask_matches, o_out_valid, o_new_umask == ~o_new_mode[8:0])

endmodule

### hw/rtl/smp_out_buf.sv
// ----------------------------------------------------------------------------
// smp_out_buf
// Two-entry result buffer: an output register plus a skid register, so the
// parser keeps taking characters while a result waits.
// ----------------------------------------------------------------------------
module smp_out_buf import smp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_data,
    output t_buf_status o_status,
    output logic        o_valid,
    output t_result     o_data,
    input  logic        i_ready
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_main_v && i_ready;

    // push is only possible while the skid slot is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_pop) begin
                if (i_push) begin
                    r_main_v <= 1'b1;
                end else begin
                    r_main_v <= r_skid_v;
                    r_skid_v <= 1'b0;
                end
            end else if (i_push) begin
                if (r_main_v) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_main_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (i_push) begin
                r_main <= i_data;
            end else begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    assign o_valid            = r_main_v;
    assign o_data             = r_main;
    assign o_status.main_full = r_main_v;
    assign o_status.skid_full = r_skid_v;

endmodule
